FILE: hdl/mrdm_pkg.sv
// shared constants and types for the macro routing demand map
package mrdm_pkg;
  localparam int MaxBinsX = 64;
  localparam int MaxBinsY = 64;
  localparam int MapDepth = MaxBinsX * MaxBinsY;
  localparam int IdxW = $clog2(MapDepth);
  localparam int AccW = 48;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_BIN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BIN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_BINS_IN_X  = 3'd4;
  localparam logic [2:0] REG_BINS_IN_Y  = 3'd5;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // divider request/response between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [12:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quotient;
  } div_rsp_t;
endpackage

FILE: hdl/macro_routing_demand_map_top.sv
// top level: configuration, sequencer, overlap and accumulate datapath
// An add beat walks every bin the macro rectangle covers, clamped to the grid,
// each bin in three steps (read, multiply, saturating write on one map port).
// Before the walk come four divisions on the shared divider, which locate the
// first and last bin columns and rows. An add with a zero bin size is dropped.
// After a read beat the result register holds the input off until the result
// beat is taken. After reset the maps are cleared by a sweep over all 4096
// entries, one entry a cycle, during which no beat is accepted.
module macro_routing_demand_map_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] size_x,
  input  logic [15:0] size_y,
  input  logic [15:0] util_horizontal,
  input  logic [15:0] util_vertical,
  input  logic [11:0] read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] bin_index,
  output logic [47:0] horizontal_demand,
  output logic [47:0] vertical_demand
);
  import mrdm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DIV = 4'd2,
                         S_DWAIT = 4'd3, S_COL = 4'd4, S_ROW = 4'd5,
                         S_RD = 4'd6, S_MUL = 4'd7, S_WR = 4'd8,
                         S_RREAD = 4'd9, S_RDATA = 4'd10, S_OUT = 4'd11;

  // configuration registers
  logic [15:0] origin_x, origin_y;
  logic [12:0] bin_width, bin_height;
  logic [6:0]  bins_in_x, bins_in_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      bin_width  <= 13'd16;
      bin_height <= 13'd16;
      bins_in_x  <= 7'd64;
      bins_in_y  <= 7'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_BIN_WIDTH:  bin_width  <= cfg_data[12:0];
        REG_BIN_HEIGHT: bin_height <= cfg_data[12:0];
        REG_BINS_IN_X:  bins_in_x  <= cfg_data[6:0];
        REG_BINS_IN_Y:  bins_in_y  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamped grid size
  logic [6:0] nx, ny;
  assign nx = (bins_in_x > 7'(MaxBinsX)) ? 7'(MaxBinsX) : bins_in_x;
  assign ny = (bins_in_y > 7'(MaxBinsY)) ? 7'(MaxBinsY) : bins_in_y;

  logic [3:0]  state;
  logic [12:0] clr_cnt;
  logic [1:0]  dsel;
  logic [16:0] xlo, xhi, ylo, yhi;
  logic [15:0] uh, uv;
  logic [11:0] ridx;
  logic [16:0] q [4];
  logic [16:0] c, r, c_end, r_end;
  logic [17:0] bxl, byl;
  logic [16:0] ox, oy;
  logic [32:0] oxh, oxv;
  logic [12:0] idx;
  logic [47:0] ph, pv;
  logic [47:0] out_h, out_v;

  div_req_t dreq;
  div_rsp_t drsp;

  mrdm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // divider operand select: x low, x high, y low, y high
  logic [16:0] dlo;
  logic [15:0] dorg;
  always_comb begin
    unique case (dsel)
      2'd0: begin dlo = xlo; dorg = origin_x; end
      2'd1: begin dlo = xhi; dorg = origin_x; end
      2'd2: begin dlo = ylo; dorg = origin_y; end
      default: begin dlo = yhi; dorg = origin_y; end
    endcase
    dreq.start    = (state == S_DIV);
    dreq.dividend = (dlo < {1'b0, dorg}) ? 17'd0 : dlo - {1'b0, dorg};
    dreq.divisor  = dsel[1] ? bin_height : bin_width;
  end

  // overlap lengths of current column and row
  logic [17:0] oxa, oxb, oya, oyb, bxh, byh;
  always_comb begin
    bxh = bxl + 18'(bin_width);
    byh = byl + 18'(bin_height);
    oxa = ({1'b0, xlo} > bxl) ? {1'b0, xlo} : bxl;
    oxb = ({1'b0, xhi} < bxh) ? {1'b0, xhi} : bxh;
    oya = ({1'b0, ylo} > byl) ? {1'b0, ylo} : byl;
    oyb = ({1'b0, yhi} < byh) ? {1'b0, yhi} : byh;
  end

  // map port
  logic             m_rd, m_wr;
  logic [IdxW-1:0]  m_raddr, m_waddr;
  logic [AccW-1:0]  m_rh, m_rv, m_wh, m_wv;
  logic [48:0]      sh, sv;

  assign sh = {1'b0, m_rh} + {1'b0, ph};
  assign sv = {1'b0, m_rv} + {1'b0, pv};

  always_comb begin
    m_rd    = (state == S_RD) || (state == S_RREAD);
    m_raddr = (state == S_RREAD) ? ridx : idx[IdxW-1:0];
    m_wr    = (state == S_CLEAR) || (state == S_WR && !idx[IdxW]);
    m_waddr = (state == S_CLEAR) ? clr_cnt[IdxW-1:0] : idx[IdxW-1:0];
    m_wh    = (state == S_CLEAR) ? '0 : (sh[48] ? AccMax : sh[47:0]);
    m_wv    = (state == S_CLEAR) ? '0 : (sv[48] ? AccMax : sv[47:0]);
  end

  mrdm_map u_map (
    .clk(clk), .rd_en(m_rd), .rd_addr(m_raddr), .rd_h(m_rh), .rd_v(m_rv),
    .wr_en(m_wr), .wr_addr(m_waddr), .wr_h(m_wh), .wr_v(m_wv)
  );

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign bin_index = ridx;
  assign horizontal_demand = out_h;
  assign vertical_demand = out_v;

  // last-bin ends, plus one and clamped
  logic [16:0] cend_n, rend_n, cx1, ry1;
  always_comb begin
    cx1 = (xhi < {1'b0, origin_x}) ? 17'd0 : q[1] + 17'd1;
    ry1 = (yhi < {1'b0, origin_y}) ? 17'd0 : q[3] + 17'd1;
    cend_n = (cx1 > 17'(nx)) ? 17'(nx) : cx1;
    rend_n = (ry1 > 17'(ny)) ? 17'(ny) : ry1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 13'd1;
          if (clr_cnt == 13'(MapDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          xlo  <= {1'b0, pos_x};
          ylo  <= {1'b0, pos_y};
          xhi  <= {1'b0, pos_x} + {1'b0, size_x};
          yhi  <= {1'b0, pos_y} + {1'b0, size_y};
          uh   <= util_horizontal;
          uv   <= util_vertical;
          ridx <= read_index;
          dsel <= 2'd0;
          if (opcode == OP_READ) state <= S_RREAD;
          else if (bin_width == '0 || bin_height == '0) state <= S_IDLE;
          else state <= S_DIV;
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: if (drsp.done) begin
          q[dsel] <= drsp.quotient;
          dsel <= dsel + 2'd1;
          state <= (dsel == 2'd3) ? S_COL : S_DIV;
        end
        S_COL: begin
          c     <= q[0];
          c_end <= cend_n;
          r_end <= rend_n;
          bxl   <= 18'(origin_x) + 18'(q[0][12:0]) * 18'(bin_width);
          state <= S_ROW;
        end
        S_ROW: begin
          if (c >= c_end || c >= 17'(MaxBinsX)) state <= S_IDLE;
          else if (r_end <= q[2]) state <= S_IDLE;
          else begin
            r     <= q[2];
            byl   <= 18'(origin_y) + 18'(q[2][12:0]) * 18'(bin_height);
            ox    <= (oxb > oxa) ? 17'(oxb - oxa) : 17'd0;
            idx   <= 13'(c[6:0]) * 13'(ny) + 13'(q[2][6:0]);
            state <= S_RD;
          end
        end
        // row overlap and column overlap times utilization
        S_RD: begin
          oy    <= (oyb > oya) ? 17'(oyb - oya) : 17'd0;
          oxh   <= 33'(ox) * 33'(uh);
          oxv   <= 33'(ox) * 33'(uv);
          state <= S_MUL;
        end
        S_MUL: begin
          ph    <= 48'(oxh) * 48'(oy);
          pv    <= 48'(oxv) * 48'(oy);
          state <= S_WR;
        end
        S_WR: begin
          if (r + 17'd1 < r_end && r + 17'd1 < 17'(MaxBinsY)) begin
            r     <= r + 17'd1;
            byl   <= byl + 18'(bin_height);
            idx   <= idx + 13'd1;
            state <= S_RD;
          end else begin
            c     <= c + 17'd1;
            bxl   <= bxl + 18'(bin_width);
            state <= S_ROW;
          end
        end
        S_RREAD: state <= S_RDATA;
        S_RDATA: begin
          out_h <= m_rh;
          out_v <= m_rv;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result only leaves from the output state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("out_valid outside output");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> in_stall) else $error("accept while busy");
  a_no_write_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RREAD) |-> !m_wr) else $error("write during read beat");
endmodule

FILE: hdl/mrdm_div.sv
// restoring divider, one quotient bit per cycle
module mrdm_div (
  input  logic               clk,
  input  logic               rst,
  input  mrdm_pkg::div_req_t req,
  output mrdm_pkg::div_rsp_t rsp
);
  import mrdm_pkg::*;

  logic [16:0] quo;
  logic [13:0] rem;
  logic [12:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [13:0] trial;
  logic [14:0] diff;

  // shift in next dividend bit and try the subtract
  always_comb begin
    trial = {rem[12:0], quo[16]};
    diff  = {1'b0, trial} - {2'b0, dvs};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd17;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[14]) begin
        rem <= diff[13:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[15:0], 1'b0};
      end
    end
  end

  assign rsp.quotient = quo;
endmodule

FILE: hdl/mrdm_map.sv
// demand maps with one read port and one write port, also used by the clearing sweep
module mrdm_map (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [mrdm_pkg::IdxW-1:0] rd_addr,
  output logic [mrdm_pkg::AccW-1:0] rd_h,
  output logic [mrdm_pkg::AccW-1:0] rd_v,
  input  logic                     wr_en,
  input  logic [mrdm_pkg::IdxW-1:0] wr_addr,
  input  logic [mrdm_pkg::AccW-1:0] wr_h,
  input  logic [mrdm_pkg::AccW-1:0] wr_v
);
  import mrdm_pkg::*;

  logic [AccW-1:0] hmem [MapDepth];
  logic [AccW-1:0] vmem [MapDepth];

  // registered read, single write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_h <= hmem[rd_addr];
      rd_v <= vmem[rd_addr];
    end
    if (wr_en) begin
      hmem[wr_addr] <= wr_h;
      vmem[wr_addr] <= wr_v;
    end
  end
endmodule
